@@ rtl/tcpq_pkg.sv @@
package tcpq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 1;
    localparam int MEM_AW      = PTR_W + 2;
    localparam int MEM_DEPTH   = 3 << PTR_W;

    // field widths
    localparam int TAG_W = 16;
    localparam int AGE_W = 4;

    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [AGE_W-1:0] AGE_THR_RESET = AGE_W'(5);

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0]
    {
        CLS_HIGH   = 2'd0,
        CLS_MIDDLE = 2'd1,
        CLS_LOW    = 2'd2,
        CLS_BAD    = 2'd3
    } cls_t;

    typedef enum logic [2:0]
    {
        ST_ENQUEUED  = 3'd0,
        ST_DEQUEUED  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_CLASS = 3'd4
    } status_t;

    // classified request handed from front to back
    typedef struct packed
    {
        logic             is_deq;
        logic             bad_class;
        cls_t             cls;
        logic [TAG_W-1:0] tag;
    } cmd_t;

endpackage

@@ rtl/tcpq_if.sv @@
interface item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [1:0]  item_class;
    logic [15:0] item_tag;

    modport source (output valid, command, item_class, item_tag, input ready);
    modport sink   (input valid, command, item_class, item_tag, output ready);
endinterface

interface result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] served_tag;
    logic [1:0]  served_class;
    logic        all_empty;

    modport source (output valid, status, served_tag, served_class, all_empty,
                    input ready);
    modport sink   (input valid, status, served_tag, served_class, all_empty,
                    output ready);
endinterface

interface cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] aging_threshold;

    modport source (output valid, aging_threshold, input ready);
    modport sink   (input valid, aging_threshold, output ready);
endinterface

@@ rtl/tcpq_front.sv @@
module tcpq_front
(
    input  logic          clk,
    input  logic          rst_n,
    item_if.sink          item_in,
    output tcpq_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import tcpq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    cmd_t       cls_cmd;
    logic       push;
    logic       pop;

    // classify the incoming request
    always_comb
    begin
        cls_cmd.is_deq    = (cmd_code_t'(item_in.command) == CMD_DEQ);
        cls_cmd.bad_class = (cls_t'(item_in.item_class) == CLS_BAD);
        cls_cmd.cls       = cls_t'(item_in.item_class);
        cls_cmd.tag       = item_in.item_tag;
    end

    // two-entry request queue
    assign item_in.ready = (fill_reg != 2'd2);
    assign push          = item_in.valid && item_in.ready;
    assign pop           = cmd_valid && cmd_ready;
    assign cmd_valid     = (fill_reg != 2'd0);
    assign cmd           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

@@ rtl/tcpq_back.sv @@
module tcpq_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  tcpq_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    cfg_if.sink            cfg,
    result_if.source       result_out
);
    import tcpq_pkg::*;

    typedef enum logic [6:0]
    {
        S_IDLE   = 7'b0000001,
        S_MID_RD = 7'b0000010,
        S_MID_WR = 7'b0000100,
        S_LOW_RD = 7'b0001000,
        S_LOW_WR = 7'b0010000,
        S_SRV_RD = 7'b0100000,
        S_SRV_WR = 7'b1000000
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    // tag storage, one region per class
    logic [TAG_W-1:0] mem [MEM_DEPTH];
    logic [TAG_W-1:0] rd_data_reg;

    state_t           state_reg;
    state_t           state_next;
    logic [PTR_W-1:0] head_reg [3];
    logic [PTR_W-1:0] head_next [3];
    logic [CNT_W-1:0] cnt_reg [3];
    logic [CNT_W-1:0] cnt_next [3];
    logic [AGE_W-1:0] mid_age_reg;
    logic [AGE_W-1:0] mid_age_next;
    logic [AGE_W-1:0] low_age_reg;
    logic [AGE_W-1:0] low_age_next;
    logic [AGE_W-1:0] thr_reg;
    cls_t             src_reg;
    cls_t             src_next;
    logic             fire_low_reg;
    logic             fire_low_next;

    logic             res_valid_reg;
    logic             res_valid_next;
    status_t          res_status_reg;
    status_t          res_status_next;
    logic [TAG_W-1:0] res_tag_reg;
    logic [TAG_W-1:0] res_tag_next;
    cls_t             res_cls_reg;
    cls_t             res_cls_next;
    logic             res_empty_reg;
    logic             res_empty_next;
    logic             res_load;

    logic [2:0]       push_vec;
    logic [2:0]       pop_vec;
    logic             can_start;
    logic             rd_en;
    cls_t             rd_cls;
    logic             wr_en;
    cls_t             wr_cls;
    logic [TAG_W-1:0] wr_data;
    logic [PTR_W-1:0] wr_slot;

    logic             hi_ne;
    logic             mid_ne;
    logic             lo_ne;
    logic [AGE_W-1:0] limit;
    logic [AGE_W-1:0] mid_age_inc;
    logic [AGE_W-1:0] low_age_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] tail_of(input logic [PTR_W-1:0] h,
                                                  input logic [CNT_W-1:0] c);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, h} + SUM_W'(c);
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        tail_of = sum[PTR_W-1:0];
    endfunction

    // configuration register, always writable
    assign cfg.ready = 1'b1;

    // a new request starts only when the result slot is free or draining
    assign can_start = !res_valid_reg || result_out.ready;

    // aging terms
    always_comb
    begin
        hi_ne       = (cnt_reg[CLS_HIGH] != '0);
        mid_ne      = (cnt_reg[CLS_MIDDLE] != '0);
        lo_ne       = (cnt_reg[CLS_LOW] != '0);
        limit       = (thr_reg == '0) ? AGE_W'(1) : thr_reg;
        mid_age_inc = (hi_ne && mid_ne && mid_age_reg != AGE_MAX)
                      ? mid_age_reg + 1'b1 : mid_age_reg;
        low_age_inc = ((hi_ne || mid_ne) && lo_ne && low_age_reg != AGE_MAX)
                      ? low_age_reg + 1'b1 : low_age_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        fire_low_next   = fire_low_reg;
        mid_age_next    = mid_age_reg;
        low_age_next    = low_age_reg;
        push_vec        = '0;
        pop_vec         = '0;
        cmd_ready       = 1'b0;
        rd_en           = 1'b0;
        rd_cls          = CLS_HIGH;
        wr_en           = 1'b0;
        wr_cls          = CLS_HIGH;
        wr_data         = rd_data_reg;
        res_load        = 1'b0;
        res_status_next = ST_EMPTY;
        res_tag_next    = '0;
        res_cls_next    = CLS_HIGH;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && can_start)
                begin
                    cmd_ready = 1'b1;
                    if (!cmd.is_deq)
                    begin
                        res_load = 1'b1;
                        if (cmd.bad_class)
                        begin
                            res_status_next = ST_BAD_CLASS;
                        end
                        else if (cnt_reg[cmd.cls] == DEPTH_CNT)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            res_status_next = ST_ENQUEUED;
                            wr_en           = 1'b1;
                            wr_cls          = cmd.cls;
                            wr_data         = cmd.tag;
                            push_vec[cmd.cls] = 1'b1;
                        end
                    end
                    else if (!hi_ne && !mid_ne)
                    begin
                        // only the low queue can serve, no aging
                        src_next      = CLS_LOW;
                        fire_low_next = 1'b0;
                        state_next    = S_SRV_RD;
                    end
                    else
                    begin
                        src_next      = hi_ne ? CLS_HIGH : CLS_MIDDLE;
                        fire_low_next = (low_age_inc >= limit);
                        mid_age_next  = (mid_age_inc >= limit) ? '0 : mid_age_inc;
                        low_age_next  = (low_age_inc >= limit) ? '0 : low_age_inc;
                        if (mid_age_inc >= limit)
                        begin
                            state_next = S_MID_RD;
                        end
                        else if (low_age_inc >= limit)
                        begin
                            state_next = S_LOW_RD;
                        end
                        else
                        begin
                            state_next = S_SRV_RD;
                        end
                    end
                end
            end

            S_MID_RD:
            begin
                if (mid_ne && cnt_reg[CLS_HIGH] != DEPTH_CNT)
                begin
                    rd_en      = 1'b1;
                    rd_cls     = CLS_MIDDLE;
                    state_next = S_MID_WR;
                end
                else
                begin
                    state_next = fire_low_reg ? S_LOW_RD : S_SRV_RD;
                end
            end

            S_MID_WR:
            begin
                wr_en                = 1'b1;
                wr_cls               = CLS_HIGH;
                push_vec[CLS_HIGH]   = 1'b1;
                pop_vec[CLS_MIDDLE]  = 1'b1;
                state_next           = fire_low_reg ? S_LOW_RD : S_SRV_RD;
            end

            S_LOW_RD:
            begin
                if (lo_ne && cnt_reg[CLS_MIDDLE] != DEPTH_CNT)
                begin
                    rd_en      = 1'b1;
                    rd_cls     = CLS_LOW;
                    state_next = S_LOW_WR;
                end
                else
                begin
                    state_next = S_SRV_RD;
                end
            end

            S_LOW_WR:
            begin
                wr_en                = 1'b1;
                wr_cls               = CLS_MIDDLE;
                push_vec[CLS_MIDDLE] = 1'b1;
                pop_vec[CLS_LOW]     = 1'b1;
                state_next           = S_SRV_RD;
            end

            S_SRV_RD:
            begin
                if (cnt_reg[src_reg] == '0)
                begin
                    res_load        = 1'b1;
                    res_status_next = ST_EMPTY;
                    state_next      = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_cls     = src_reg;
                    state_next = S_SRV_WR;
                end
            end

            S_SRV_WR:
            begin
                pop_vec[src_reg] = 1'b1;
                res_load         = 1'b1;
                res_status_next  = ST_DEQUEUED;
                res_tag_next     = rd_data_reg;
                res_cls_next     = src_reg;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // pointer and fill bookkeeping per class
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            head_next[k] = pop_vec[k] ? ptr_inc(head_reg[k]) : head_reg[k];
            cnt_next[k]  = cnt_reg[k] + CNT_W'(push_vec[k]) - CNT_W'(pop_vec[k]);
        end
        wr_slot        = tail_of(head_reg[wr_cls], cnt_reg[wr_cls]);
        res_empty_next = (cnt_next[CLS_HIGH] == '0) && (cnt_next[CLS_MIDDLE] == '0)
                         && (cnt_next[CLS_LOW] == '0);
        res_valid_next = res_load ? 1'b1 : (result_out.ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mid_age_reg   <= '0;
            low_age_reg   <= '0;
            thr_reg       <= AGE_THR_RESET;
            src_reg       <= CLS_HIGH;
            fire_low_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mid_age_reg   <= mid_age_next;
            low_age_reg   <= low_age_next;
            src_reg       <= src_next;
            fire_low_reg  <= fire_low_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.aging_threshold;
            end
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= head_next[k];
                cnt_reg[k]  <= cnt_next[k];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_tag_reg    <= res_tag_next;
            res_cls_reg    <= res_cls_next;
            res_empty_reg  <= res_empty_next;
        end
    end

    // tag memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_cls, wr_slot}] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_cls, head_reg[rd_cls]}];
        end
    end

    assign result_out.valid        = res_valid_reg;
    assign result_out.status       = res_status_reg;
    assign result_out.served_tag   = res_tag_reg;
    assign result_out.served_class = res_cls_reg;
    assign result_out.all_empty    = res_empty_reg;

endmodule

@@ rtl/three_class_priority_queue_aging.sv @@
// enqueue: the request is checked and its tag written in S_IDLE; the result is registered
// dequeue: optional promotions (S_MID_RD/S_MID_WR, then S_LOW_RD/S_LOW_WR), then serving
// (S_SRV_RD, S_SRV_WR); a promotion is skipped when its source is empty or its target full,
// and serving ends in S_SRV_RD when the source queue is empty
// a two-entry request queue keeps taking requests while the back end works, until it is full
// reset: all queues empty, age counters 0, aging threshold 5; tag memory not cleared
module three_class_priority_queue_aging
(
    input  logic     clk,
    input  logic     rst_n,
    item_if.sink     item_in,
    cfg_if.sink      cfg,
    result_if.source result_out
);
    import tcpq_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    // request intake and classification
    tcpq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    // queue storage, aging and serving
    tcpq_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cfg        (cfg),
        .result_out (result_out)
    );

endmodule

@@ rtl/tcpq_checker.sv @@
module tcpq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  res_status,
    input logic [15:0] res_tag,
    input logic [1:0]  res_class,
    input logic        res_all_empty
);
    import tcpq_pkg::*;

    // a pending result is held until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    // only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status <= ST_BAD_CLASS)
        else $error("undefined status code");

    // tag and class are zero unless an item was served
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_DEQUEUED |-> res_tag == '0 && res_class == '0)
        else $error("payload not cleared on non-dequeue result");

    // a waiting result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready
        |=> $stable({res_status, res_tag, res_class, res_all_empty}))
        else $error("result payload changed while waiting");

endmodule

bind three_class_priority_queue_aging tcpq_checker u_tcpq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result_out.valid),
    .res_ready     (result_out.ready),
    .res_status    (result_out.status),
    .res_tag       (result_out.served_tag),
    .res_class     (result_out.served_class),
    .res_all_empty (result_out.all_empty)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import tcpq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 100;
    localparam int HOLD_AFTER     = 150;
    localparam int MAX_PRINTED    = 40;

    typedef struct
    {
        cmd_code_t        command;
        cls_t             cls;
        logic [TAG_W-1:0] tag;
    } queue_req_t;

    typedef struct
    {
        status_t          status;
        logic [TAG_W-1:0] tag;
        cls_t             cls;
        logic             all_empty;
    } queue_result_t;

    logic clk;
    logic rst_n;

    item_if   item_bus ();
    cfg_if    cfg_bus ();
    result_if result_bus ();

    three_class_priority_queue_aging DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .cfg        (cfg_bus),
        .result_out (result_bus)
    );

    // requests waiting to be offered, results waiting to arrive
    queue_req_t    pending_reqs [$];
    queue_result_t expected_results [$];

    int error_count;
    int results_seen;
    int idle_cycles;
    int send_gap;
    int recv_stall;
    int recv_hold;
    bit hold_done;
    bit quiet;

    // predicted queue contents and aging state
    logic [TAG_W-1:0] ring_mem [3][QUEUE_DEPTH];
    int               ring_head [3];
    int               ring_fill [3];
    logic [AGE_W-1:0] age_limit;
    logic [AGE_W-1:0] mid_age;
    logic [AGE_W-1:0] low_age;

    function automatic void ring_push(input int q, input logic [TAG_W-1:0] tag);
        ring_mem[q][(ring_head[q] + ring_fill[q]) % QUEUE_DEPTH] = tag;
        ring_fill[q] = ring_fill[q] + 1;
    endfunction

    function automatic logic [TAG_W-1:0] ring_pop(input int q);
        logic [TAG_W-1:0] tag;
        tag          = ring_mem[q][ring_head[q]];
        ring_head[q] = (ring_head[q] + 1) % QUEUE_DEPTH;
        ring_fill[q] = ring_fill[q] - 1;
        return tag;
    endfunction

    function automatic void promote(input int from_q, input int to_q);
        if (ring_fill[from_q] != 0 && ring_fill[to_q] < QUEUE_DEPTH)
            ring_push(to_q, ring_pop(from_q));
    endfunction

    // aging: both bump conditions judged before any move
    function automatic void run_aging();
        logic [AGE_W-1:0] thr;
        bit               bump_mid;
        bit               bump_low;
        thr      = (age_limit == '0) ? AGE_W'(1) : age_limit;
        bump_mid = ring_fill[CLS_HIGH] != 0 && ring_fill[CLS_MIDDLE] != 0;
        bump_low = (ring_fill[CLS_HIGH] != 0 || ring_fill[CLS_MIDDLE] != 0)
                   && ring_fill[CLS_LOW] != 0;
        if (bump_mid && mid_age != AGE_MAX)
            mid_age = mid_age + 1'b1;
        if (bump_low && low_age != AGE_MAX)
            low_age = low_age + 1'b1;
        if (mid_age >= thr)
        begin
            promote(CLS_MIDDLE, CLS_HIGH);
            mid_age = '0;
        end
        if (low_age >= thr)
        begin
            promote(CLS_LOW, CLS_MIDDLE);
            low_age = '0;
        end
    endfunction

    function automatic queue_result_t serve_request(input queue_req_t req);
        queue_result_t res;
        int            src;
        res.status = ST_ENQUEUED;
        res.tag    = '0;
        res.cls    = CLS_HIGH;
        if (req.command == CMD_ENQ)
        begin
            if (req.cls == CLS_BAD)
                res.status = ST_BAD_CLASS;
            else if (ring_fill[req.cls] >= QUEUE_DEPTH)
                res.status = ST_FULL;
            else
                ring_push(req.cls, req.tag);
        end
        else
        begin
            // source class is fixed before aging moves anything
            if (ring_fill[CLS_HIGH] != 0)
            begin
                run_aging();
                src = CLS_HIGH;
            end
            else if (ring_fill[CLS_MIDDLE] != 0)
            begin
                run_aging();
                src = CLS_MIDDLE;
            end
            else
                src = CLS_LOW;
            if (ring_fill[src] == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.tag    = ring_pop(src);
                res.cls    = cls_t'(src);
                res.status = ST_DEQUEUED;
            end
        end
        res.all_empty = ring_fill[CLS_HIGH] == 0 && ring_fill[CLS_MIDDLE] == 0
                        && ring_fill[CLS_LOW] == 0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count = error_count + 1;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic add_request(input cmd_code_t command, input cls_t cls,
                               input logic [TAG_W-1:0] tag);
        queue_req_t req;
        req.command = command;
        req.cls     = cls;
        req.tag     = tag;
        pending_reqs.push_back(req);
    endtask

    // random requests in fill-heavy and drain-heavy stretches
    task automatic add_random_requests(input int count);
        int        left;
        int        seg;
        int        enq_pct;
        cmd_code_t command;
        cls_t      cls;
        left = count;
        while (left > 0)
        begin
            seg     = $urandom_range(8, 40);
            enq_pct = ($urandom_range(0, 1) == 1) ? 75 : 30;
            while (seg > 0 && left > 0)
            begin
                command = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                cls     = ($urandom_range(0, 11) == 0) ? CLS_BAD
                          : cls_t'($urandom_range(0, 2));
                add_request(command, cls, TAG_W'($urandom_range(0, 16'hFFFF)));
                seg  = seg - 1;
                left = left - 1;
            end
        end
    endtask

    task automatic write_threshold(input logic [AGE_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid           <= 1'b1;
        cfg_bus.aging_threshold <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        age_limit     = value;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bit offering;
        bit next_valid;
        if (!rst_n)
        begin
            item_bus.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            offering = item_bus.valid;
            if (item_bus.valid && item_bus.ready)
            begin
                expected_results.push_back(serve_request(pending_reqs.pop_front()));
                offering = 1'b0;
            end
            next_valid = offering;
            if (!offering)
            begin
                if (send_gap > 0)
                begin
                    send_gap   = send_gap - 1;
                    next_valid = 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    next_valid = 1'b0;
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    send_gap   = $urandom_range(0, 7);
                    next_valid = 1'b0;
                end
                else
                begin
                    next_valid          = 1'b1;
                    item_bus.command    <= pending_reqs[0].command;
                    item_bus.item_class <= pending_reqs[0].cls;
                    item_bus.item_tag   <= pending_reqs[0].tag;
                end
            end
            item_bus.valid <= next_valid;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        queue_result_t want;
        bit            next_ready;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_stall = 0;
            recv_hold  = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                results_seen = results_seen + 1;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result, status %0d",
                                              result_bus.status));
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  result_bus.status, want.status));
                    if (result_bus.served_tag !== want.tag)
                        report_mismatch($sformatf("served_tag %h, wanted %h",
                                                  result_bus.served_tag, want.tag));
                    if (result_bus.served_class !== want.cls)
                        report_mismatch($sformatf("served_class %0d, wanted %0d",
                                                  result_bus.served_class, want.cls));
                    if (result_bus.all_empty !== want.all_empty)
                        report_mismatch($sformatf("all_empty %0b, wanted %0b",
                                                  result_bus.all_empty, want.all_empty));
                end
            end
            // short random stalls, and once one long hold-off to back the block up
            if (recv_hold > 0)
            begin
                recv_hold  = recv_hold - 1;
                next_ready = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                recv_hold  = HOLD_CYCLES - 1;
                next_ready = 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall = recv_stall - 1;
                next_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(0, 7);
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            result_bus.ready <= next_ready;
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) ||
                (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // reset, phases of threshold settings, end of run
    initial
    begin : run_control
        logic [AGE_W-1:0] phase_thr [7];
        int               phase_len [7];
        phase_thr = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd15, 4'd8, 4'd2};
        phase_len = '{90, 90, 70, 90, 80, 80, 80};

        error_count  = 0;
        results_seen = 0;
        idle_cycles  = 0;
        hold_done    = 1'b0;
        quiet        = 1'b0;
        age_limit    = AGE_THR_RESET;
        mid_age      = '0;
        low_age      = '0;
        for (int q = 0; q < 3; q++)
        begin
            ring_head[q] = 0;
            ring_fill[q] = 0;
        end

        rst_n                   = 1'b0;
        item_bus.valid          = 1'b0;
        item_bus.command        = CMD_ENQ;
        item_bus.item_class     = CLS_HIGH;
        item_bus.item_tag       = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.aging_threshold = AGE_THR_RESET;
        result_bus.ready        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty dequeue, bad class, tag extremes in the low and high classes
        add_request(CMD_DEQ, CLS_HIGH, 16'h0000);
        add_request(CMD_ENQ, CLS_BAD, 16'hFFFF);
        add_request(CMD_ENQ, CLS_BAD, 16'h0000);
        add_request(CMD_ENQ, CLS_LOW, 16'h0000);
        add_request(CMD_ENQ, CLS_LOW, 16'hFFFF);
        add_request(CMD_ENQ, CLS_MIDDLE, 16'h1234);
        add_request(CMD_ENQ, CLS_MIDDLE, 16'hFFFF);
        add_request(CMD_ENQ, CLS_HIGH, 16'hFFFF);
        add_request(CMD_ENQ, CLS_HIGH, 16'h0000);
        add_request(CMD_ENQ, CLS_HIGH, 16'h5A5A);
        add_request(CMD_DEQ, CLS_BAD, 16'hFFFF);
        repeat (7) add_request(CMD_DEQ, CLS_HIGH, 16'h0000);
        add_request(CMD_ENQ, CLS_LOW, 16'hA5A5);
        add_request(CMD_DEQ, CLS_LOW, 16'h0000);
        add_request(CMD_DEQ, CLS_MIDDLE, 16'hFFFF);
        wait_idle();

        for (int p = 0; p < 7; p++)
        begin
            write_threshold(phase_thr[p]);
            if (p == 6)
                quiet = 1'b1;
            add_random_requests(phase_len[p]);
            wait_idle();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
